FILE: rtl/tfu_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed widths for the per-triangle tangent block.
package tfu_pkg;

  // One vertex: position and texture coordinate, signed fixed point
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } tfu_in_t;

  // One result: unit tangent in Q2.30 plus flags
  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic               degenerate;
    logic               last_of_triangle;
  } tfu_out_t;

  localparam int OUT_FRAC = 30;          // fraction bits of the result
  localparam int DW  = 33;               // edge / uv delta width
  localparam int PW  = 2 * DW;           // product and tangent component width
  localparam int MW  = PW - 1;           // tangent magnitude width
  localparam int AW  = OUT_FRAC + 1;     // normalised magnitude width
  localparam int QW  = OUT_FRAC + 1;     // unit magnitude width (up to 2^30)
  localparam int SQW = 2 * AW;           // square of a normalised magnitude
  localparam int SW  = 64;               // sum of three squares
  localparam int RW  = SQW + 2 * OUT_FRAC; // root remainder width
  localparam int GW  = 128;              // root trial term width
  localparam int BW  = 5;                // root bit counter width

  localparam logic [1:0] COPIES = 2'd3;  // results per triangle

endpackage

FILE: rtl/tfu_mul.sv
`timescale 1ns / 1ps
// Shared signed 33x33 multiplier with registered product.
module tfu_mul (
  input  logic                          clk,
  input  logic signed [tfu_pkg::DW-1:0] a,
  input  logic signed [tfu_pkg::DW-1:0] b,
  output logic signed [tfu_pkg::PW-1:0] p
);

  logic signed [tfu_pkg::PW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= tfu_pkg::PW'(a) * tfu_pkg::PW'(b);
  end

  assign p = p_r;

endmodule

FILE: rtl/tfu_umag.sv
`timescale 1ns / 1ps
// Bit-serial unit magnitude: largest q with q^2 * s <= sq * 2^60, each bit in a trial phase then an update phase.
module tfu_umag (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tfu_pkg::SQW-1:0]      sq,
  input  logic [tfu_pkg::SW-1:0]       s,
  output logic                         done,
  output logic [tfu_pkg::QW-1:0]       q
);

  logic                        busy_r;
  logic                        phase_r;
  logic                        done_r;
  logic [tfu_pkg::BW-1:0]      bit_r;
  logic [tfu_pkg::RW-1:0]      rem_r;
  logic [tfu_pkg::GW-1:0]      g_r;
  logic [tfu_pkg::GW-1:0]      h_r;
  logic [tfu_pkg::GW-1:0]      trial_r;
  logic [tfu_pkg::QW-1:0]      q_r;

  logic [tfu_pkg::GW:0]        diff;
  logic                        fits;
  logic [tfu_pkg::GW-1:0]      g_new;

  // remainder minus trial; no borrow means the trial bit is kept
  assign diff  = {1'b0, (tfu_pkg::GW - tfu_pkg::RW)'(0), rem_r} - {1'b0, trial_r};
  assign fits  = ~diff[tfu_pkg::GW];
  assign g_new = fits ? (trial_r + h_r) : g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
      end else if (busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r && bit_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // g = 2^(b+1) * q * s, h = 2^(2b) * s, rem = sq * 2^60 - q^2 * s
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {sq, (2 * tfu_pkg::OUT_FRAC)'(0)};
      g_r   <= '0;
      h_r   <= {(tfu_pkg::GW - tfu_pkg::SW - 2 * tfu_pkg::OUT_FRAC)'(0), s,
                (2 * tfu_pkg::OUT_FRAC)'(0)};
      q_r   <= '0;
      bit_r <= tfu_pkg::BW'(tfu_pkg::OUT_FRAC);
    end else if (busy_r) begin
      if (!phase_r) begin
        trial_r <= g_r + h_r;
      end else begin
        if (fits) begin
          rem_r <= diff[tfu_pkg::RW-1:0];
          q_r   <= q_r | (tfu_pkg::QW'(1) << bit_r);
        end
        g_r   <= g_new >> 1;
        h_r   <= h_r >> 2;
        bit_r <= bit_r - tfu_pkg::BW'(1);
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

FILE: rtl/triangle_tangent_from_uv_core.sv
`timescale 1ns / 1ps
// The first and second corner of a triangle are stored in registers as they are taken.
// The third corner starts the computation: 8 multiplies, a normalising shift, 3 squares,
// then 3 bit-serial roots in turn on the shared root unit.
// A new triangle is taken only after the previous one has reached the output register.
// Results are three copies from an output register; the next triangle's corners
// are taken while they drain. Synchronous active-low reset clears control only.
module triangle_tangent_from_uv_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tfu_pkg::tfu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tfu_pkg::tfu_out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_NORM = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                      state_r;
  logic [1:0]                      corner_r;
  logic [3:0]                      step_r;
  logic                            root_go_r;
  logic [1:0]                      out_cnt_r;

  logic signed [31:0]              hp_r [0:5];
  logic signed [31:0]              ht_r [0:3];
  logic signed [tfu_pkg::DW-1:0]   e1_r [0:2];
  logic signed [tfu_pkg::DW-1:0]   e2_r [0:2];
  logic signed [tfu_pkg::DW-1:0]   du1_r, dv1_r, du2_r, dv2_r;
  logic signed [tfu_pkg::PW-1:0]   acc_r;
  logic signed [tfu_pkg::PW-1:0]   det_r;
  logic signed [tfu_pkg::PW-1:0]   t_r [0:2];
  logic [tfu_pkg::MW-1:0]          mag_r [0:2];
  logic                            sgn_r [0:2];
  logic                            degen_r;
  logic [tfu_pkg::SQW-1:0]         sq_r [0:2];
  logic [tfu_pkg::SW-1:0]          s_r;
  logic [tfu_pkg::QW-1:0]          q_r [0:2];
  logic signed [31:0]              res_r [0:2];

  logic                            in_acc;
  logic                            out_acc;
  logic signed [tfu_pkg::DW-1:0]   mul_a, mul_b;
  logic signed [tfu_pkg::PW-1:0]   mul_p;
  logic [tfu_pkg::SQW-1:0]         rt_sq;
  logic                            rt_done;
  logic [tfu_pkg::QW-1:0]          rt_q;
  logic                            hi_any;
  logic                            top_set;
  logic                            t_zero;
  logic [tfu_pkg::PW-1:0]          t_abs [0:2];

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (out_cnt_r != 2'd0);
  assign out_acc   = out_valid && out_ready;

  assign out_data.tangent_x        = res_r[0];
  assign out_data.tangent_y        = res_r[1];
  assign out_data.tangent_z        = res_r[2];
  assign out_data.degenerate       = degen_r;
  assign out_data.last_of_triangle = (out_cnt_r == 2'd1);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        mul_b = step_r[0] ? dv1_r : dv2_r;
        case (step_r[2:1])
          2'd0:    mul_a = step_r[0] ? du2_r : du1_r;
          2'd1:    mul_a = step_r[0] ? e2_r[0] : e1_r[0];
          2'd2:    mul_a = step_r[0] ? e2_r[1] : e1_r[1];
          default: mul_a = step_r[0] ? e2_r[2] : e1_r[2];
        endcase
      end
      S_SQ: begin
        case (step_r[1:0])
          2'd0:    mul_a = {2'b00, mag_r[0][tfu_pkg::AW-1:0]};
          2'd1:    mul_a = {2'b00, mag_r[1][tfu_pkg::AW-1:0]};
          default: mul_a = {2'b00, mag_r[2][tfu_pkg::AW-1:0]};
        endcase
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (step_r[1:0])
      2'd0:    rt_sq = sq_r[0];
      2'd1:    rt_sq = sq_r[1];
      default: rt_sq = sq_r[2];
    endcase
  end

  assign hi_any  = (|mag_r[0][tfu_pkg::MW-1:tfu_pkg::AW]) |
                   (|mag_r[1][tfu_pkg::MW-1:tfu_pkg::AW]) |
                   (|mag_r[2][tfu_pkg::MW-1:tfu_pkg::AW]);
  assign top_set = mag_r[0][tfu_pkg::OUT_FRAC] | mag_r[1][tfu_pkg::OUT_FRAC] |
                   mag_r[2][tfu_pkg::OUT_FRAC];
  assign t_zero  = (t_r[0] == '0) && (t_r[1] == '0) && (t_r[2] == '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_abs[i] = t_r[i][tfu_pkg::PW-1] ? -t_r[i] : t_r[i];
    end
  end

  tfu_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  tfu_umag u_umag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_go_r),
    .sq    (rt_sq),
    .s     (s_r),
    .done  (rt_done),
    .q     (rt_q)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      corner_r  <= 2'd0;
      step_r    <= '0;
      root_go_r <= 1'b0;
      out_cnt_r <= 2'd0;
    end else begin
      root_go_r <= 1'b0;
      if (out_acc) begin
        out_cnt_r <= out_cnt_r - 2'd1;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (corner_r == 2'd2) begin
              corner_r <= 2'd0;
              step_r   <= '0;
              state_r  <= S_MUL;
            end else begin
              corner_r <= corner_r + 2'd1;
            end
          end
        end
        S_MUL: begin
          if (step_r == 4'd8) begin
            state_r <= S_FIX;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_FIX: begin
          state_r <= ((det_r == '0) || t_zero) ? S_OUT : S_NORM;
        end
        S_NORM: begin
          if (!hi_any && top_set) begin
            step_r  <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (step_r == 4'd3) begin
            step_r    <= '0;
            root_go_r <= 1'b1;
            state_r   <= S_ROOT;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        S_ROOT: begin
          if (rt_done) begin
            if (step_r == 4'd2) begin
              state_r <= S_OUT;
            end else begin
              step_r    <= step_r + 4'd1;
              root_go_r <= 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_cnt_r <= tfu_pkg::COPIES;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (corner_r == 2'd2) begin
            e1_r[0] <= {hp_r[3][31], hp_r[3]} - {hp_r[0][31], hp_r[0]};
            e1_r[1] <= {hp_r[4][31], hp_r[4]} - {hp_r[1][31], hp_r[1]};
            e1_r[2] <= {hp_r[5][31], hp_r[5]} - {hp_r[2][31], hp_r[2]};
            e2_r[0] <= {in_data.pos_x[31], in_data.pos_x} - {hp_r[0][31], hp_r[0]};
            e2_r[1] <= {in_data.pos_y[31], in_data.pos_y} - {hp_r[1][31], hp_r[1]};
            e2_r[2] <= {in_data.pos_z[31], in_data.pos_z} - {hp_r[2][31], hp_r[2]};
            du1_r   <= {ht_r[2][31], ht_r[2]} - {ht_r[0][31], ht_r[0]};
            dv1_r   <= {ht_r[3][31], ht_r[3]} - {ht_r[1][31], ht_r[1]};
            du2_r   <= {in_data.tex_u[31], in_data.tex_u} - {ht_r[0][31], ht_r[0]};
            dv2_r   <= {in_data.tex_v[31], in_data.tex_v} - {ht_r[1][31], ht_r[1]};
          end else if (corner_r[0]) begin
            hp_r[3] <= in_data.pos_x;
            hp_r[4] <= in_data.pos_y;
            hp_r[5] <= in_data.pos_z;
            ht_r[2] <= in_data.tex_u;
            ht_r[3] <= in_data.tex_v;
          end else begin
            hp_r[0] <= in_data.pos_x;
            hp_r[1] <= in_data.pos_y;
            hp_r[2] <= in_data.pos_z;
            ht_r[0] <= in_data.tex_u;
            ht_r[1] <= in_data.tex_v;
          end
        end
      end
      S_MUL: begin
        // product requested in the previous step arrives from the multiplier's output register
        case (step_r)
          4'd1, 4'd3, 4'd5, 4'd7: acc_r <= mul_p;
          4'd2:    det_r  <= acc_r - mul_p;
          4'd4:    t_r[0] <= acc_r - mul_p;
          4'd6:    t_r[1] <= acc_r - mul_p;
          4'd8:    t_r[2] <= acc_r - mul_p;
          default: ;
        endcase
      end
      S_FIX: begin
        degen_r <= (det_r == '0) || t_zero;
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= t_abs[i][tfu_pkg::MW-1:0];
          sgn_r[i] <= t_r[i][tfu_pkg::PW-1] ^ det_r[tfu_pkg::PW-1];
        end
      end
      S_NORM: begin
        // truncating right shifts one at a time equal one long truncating shift
        for (int i = 0; i < 3; i++) begin
          if (hi_any) begin
            mag_r[i] <= mag_r[i] >> 1;
          end else if (!top_set) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
      end
      S_SQ: begin
        case (step_r)
          4'd1: begin
            sq_r[0] <= mul_p[tfu_pkg::SQW-1:0];
            s_r     <= tfu_pkg::SW'(mul_p[tfu_pkg::SQW-1:0]);
          end
          4'd2: begin
            sq_r[1] <= mul_p[tfu_pkg::SQW-1:0];
            s_r     <= s_r + tfu_pkg::SW'(mul_p[tfu_pkg::SQW-1:0]);
          end
          4'd3: begin
            sq_r[2] <= mul_p[tfu_pkg::SQW-1:0];
            s_r     <= s_r + tfu_pkg::SW'(mul_p[tfu_pkg::SQW-1:0]);
          end
          default: ;
        endcase
      end
      S_ROOT: begin
        if (rt_done) begin
          case (step_r[1:0])
            2'd0:    q_r[0] <= rt_q;
            2'd1:    q_r[1] <= rt_q;
            default: q_r[2] <= rt_q;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid) begin
          for (int i = 0; i < 3; i++) begin
            if (degen_r) begin
              res_r[i] <= '0;
            end else if (sgn_r[i]) begin
              res_r[i] <= -{1'b0, q_r[i]};
            end else begin
              res_r[i] <= {1'b0, q_r[i]};
            end
          end
        end
      end
      default: ;
    endcase
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.tangent_x == '0 && out_data.tangent_y == '0 && out_data.tangent_z == '0)
    else $error("degenerate result carries a non-zero tangent");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |->
      out_data.tangent_x != '0 || out_data.tangent_y != '0 || out_data.tangent_z != '0)
    else $error("non-degenerate result has a zero tangent");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_of_triangle |=> !out_valid)
    else $error("output still valid after the last copy was taken");

  a_first_copy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !out_data.last_of_triangle)
    else $error("new triangle starts on its last copy");

  a_copy_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_triangle |=>
      out_valid && $stable(out_data.tangent_x) && $stable(out_data.degenerate))
    else $error("copies of one triangle differ");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the per-triangle tangent core.
module tb;

  localparam int IDLE_LIMIT   = 3000;   // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES = 300;    // longer than one triangle's worst latency
  localparam int RANDOM_TRIS  = 76;
  localparam int PAUSE_TRI    = 40;     // sender waits for the result queue to empty here
  localparam int REPORT_MAX   = 10;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] FX_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] FX_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] FX_MAX  = 32'sh7fff_ffff;

  typedef struct {
    tfu_pkg::tfu_in_t  vert;
    bit                known;
    tfu_pkg::tfu_out_t tangent;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  tfu_pkg::tfu_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  tfu_pkg::tfu_out_t out_data;

  triangle_tangent_from_uv_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // corners of the triangle being assembled
  tfu_pkg::tfu_in_t corner_hold [2];
  int unsigned      corners_held = 0;

  tfu_pkg::tfu_out_t tangent_q [$];
  stim_row_t         directed [$];

  bit                row_known = 1'b0;
  tfu_pkg::tfu_out_t row_tangent;
  bit                no_idle = 1'b0;

  tfu_pkg::tfu_out_t predicted;
  tfu_pkg::tfu_out_t seen;
  tfu_pkg::tfu_out_t want;

  int mismatches      = 0;
  int results_checked = 0;
  int degenerate_seen = 0;
  int vertices_sent   = 0;
  int idle_cycles     = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int msb_of(logic [127:0] x);
    for (int i = 127; i >= 0; i--)
      if (x[i]) return i;
    return -1;
  endfunction

  // largest q with q^2 * s <= a^2 * 2^60
  function automatic logic [31:0] unit_component(logic [63:0] a, logic [63:0] s);
    logic [127:0] lim;
    logic [127:0] q;
    logic [127:0] c;
    lim = (128'(a) * 128'(a)) << (2 * tfu_pkg::OUT_FRAC);
    q = '0;
    for (int b = tfu_pkg::OUT_FRAC; b >= 0; b--) begin
      c = q | (128'd1 << b);
      if (c * c * 128'(s) <= lim) q = c;
    end
    return q[31:0];
  endfunction

  function automatic tfu_pkg::tfu_out_t triangle_tangent(tfu_pkg::tfu_in_t c0,
                                                         tfu_pkg::tfu_in_t c1,
                                                         tfu_pkg::tfu_in_t c2);
    tfu_pkg::tfu_in_t    cs [3];
    logic signed [127:0] p [3][3];
    logic signed [127:0] uv [3][2];
    logic signed [127:0] e1 [3];
    logic signed [127:0] e2 [3];
    logic signed [127:0] t [3];
    logic signed [127:0] du1, dv1, du2, dv2, det;
    logic [127:0]        m [3];
    logic [63:0]         a [3];
    logic [63:0]         s;
    logic [31:0]         comp [3];
    logic [31:0]         q;
    int                  top, k;
    tfu_pkg::tfu_out_t   r;
    cs[0] = c0;
    cs[1] = c1;
    cs[2] = c2;
    for (int j = 0; j < 3; j++) begin
      p[j][0]  = $signed(cs[j].pos_x);
      p[j][1]  = $signed(cs[j].pos_y);
      p[j][2]  = $signed(cs[j].pos_z);
      uv[j][0] = $signed(cs[j].tex_u);
      uv[j][1] = $signed(cs[j].tex_v);
    end
    du1 = uv[1][0] - uv[0][0];
    dv1 = uv[1][1] - uv[0][1];
    du2 = uv[2][0] - uv[0][0];
    dv2 = uv[2][1] - uv[0][1];
    det = du1 * dv2 - du2 * dv1;
    top = -1;
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[1][i] - p[0][i];
      e2[i] = p[2][i] - p[0][i];
      t[i]  = e1[i] * dv2 - e2[i] * dv1;
      if (det < 0) t[i] = -t[i];
      m[i] = (t[i] < 0) ? -t[i] : t[i];
      k = msb_of(m[i]);
      if (k > top) top = k;
    end
    r = '0;
    r.degenerate = (det == 0) || (top < 0);
    if (!r.degenerate) begin
      s = '0;
      // common shift so the largest magnitude tops out at bit 30
      for (int i = 0; i < 3; i++) begin
        a[i] = (top <= tfu_pkg::OUT_FRAC) ? 64'(m[i] << (tfu_pkg::OUT_FRAC - top))
                                          : 64'(m[i] >> (top - tfu_pkg::OUT_FRAC));
        s += a[i] * a[i];
      end
      for (int i = 0; i < 3; i++) begin
        q = unit_component(a[i], s);
        comp[i] = (t[i] < 0) ? -q : q;
      end
      r.tangent_x = comp[0];
      r.tangent_y = comp[1];
      r.tangent_z = comp[2];
    end
    return r;
  endfunction

  function automatic tfu_pkg::tfu_in_t vtx(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, logic signed [31:0] u,
                                           logic signed [31:0] v);
    tfu_pkg::tfu_in_t r;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.tex_u = u;
    r.tex_v = v;
    return r;
  endfunction

  function automatic logic signed [31:0] small_fx();
    return int'($urandom_range(0, 32'd8388608)) - 32'sd4194304;
  endfunction

  task automatic add_row(tfu_pkg::tfu_in_t v, bit known, logic signed [31:0] tx,
                         logic signed [31:0] ty, logic signed [31:0] tz, bit degen);
    stim_row_t r;
    r.vert    = v;
    r.known   = known;
    r.tangent = '0;
    r.tangent.tangent_x  = tx;
    r.tangent.tangent_y  = ty;
    r.tangent.tangent_z  = tz;
    r.tangent.degenerate = degen;
    directed = {directed, r};
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_vertex(tfu_pkg::tfu_in_t v, int gap, bit drain);
    if (drain) gap = gap + 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      while (drain && tangent_q.size() != 0) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // input side predicts, output side checks; one block keeps the order fixed
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      vertices_sent++;
      if (corners_held < 2) begin
        corner_hold[corners_held] = in_data;
        corners_held++;
      end else begin
        corners_held = 0;
        predicted = triangle_tangent(corner_hold[0], corner_hold[1], in_data);
        if (row_known) predicted = row_tangent;
        for (int k = 0; k < int'(tfu_pkg::COPIES); k++) begin
          predicted.last_of_triangle = (k == int'(tfu_pkg::COPIES) - 1);
          tangent_q = {tangent_q, predicted};
        end
      end
    end
    if (rst_n && out_valid && out_ready) begin
      seen = out_data;
      results_checked++;
      if (seen.degenerate) degenerate_seen++;
      if (tangent_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t unexpected result x=%h y=%h z=%h deg=%b last=%b", $realtime,
                   seen.tangent_x, seen.tangent_y, seen.tangent_z,
                   seen.degenerate, seen.last_of_triangle);
      end else begin
        want = tangent_q.pop_front();
        if (seen.tangent_x !== want.tangent_x || seen.tangent_y !== want.tangent_y ||
            seen.tangent_z !== want.tangent_z || seen.degenerate !== want.degenerate ||
            seen.last_of_triangle !== want.last_of_triangle) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t mismatch: exp %h %h %h deg=%b last=%b, got %h %h %h deg=%b last=%b",
                     $realtime, want.tangent_x, want.tangent_y, want.tangent_z,
                     want.degenerate, want.last_of_triangle,
                     seen.tangent_x, seen.tangent_y, seen.tangent_z,
                     seen.degenerate, seen.last_of_triangle);
        end
      end
    end
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, tangent_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random back-pressure per transaction, none while no_idle is set
  initial begin
    int stall;
    out_ready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    tfu_pkg::tfu_in_t tri_v [3];
    int               kind;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // unit x: du along e1
    add_row(vtx(0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
    add_row(vtx(FX_ONE, 0, 0, FX_ONE, 0), 0, 0, 0, 0, 0);
    add_row(vtx(0, FX_ONE, 0, 0, FX_ONE), 1, Q30_ONE, 0, 0, 1'b0);
    // swapped uv, negative determinant flips the sign back to +y
    add_row(vtx(0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
    add_row(vtx(FX_ONE, 0, 0, 0, FX_ONE), 0, 0, 0, 0, 0);
    add_row(vtx(0, FX_ONE, 0, FX_ONE, 0), 1, 0, Q30_ONE, 0, 1'b0);
    // tangent along -z
    add_row(vtx(0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
    add_row(vtx(0, 0, -FX_ONE, FX_ONE, 0), 0, 0, 0, 0, 0);
    add_row(vtx(0, FX_ONE, 0, 0, FX_ONE), 1, 0, 0, -Q30_ONE, 1'b0);
    // all uv equal: zero determinant
    add_row(vtx(0, 0, 0, 7 * FX_ONE, 7 * FX_ONE), 0, 0, 0, 0, 0);
    add_row(vtx(FX_ONE, 0, 0, 7 * FX_ONE, 7 * FX_ONE), 0, 0, 0, 0, 0);
    add_row(vtx(0, FX_ONE, 0, 7 * FX_ONE, 7 * FX_ONE), 1, 0, 0, 0, 1'b1);
    // coincident corners, valid uv: zero tangent vector
    add_row(vtx(5, 5, 5, 0, 0), 0, 0, 0, 0, 0);
    add_row(vtx(5, 5, 5, FX_ONE, 0), 0, 0, 0, 0, 0);
    add_row(vtx(5, 5, 5, 0, FX_ONE), 1, 0, 0, 0, 1'b1);
    // full-range extremes
    add_row(vtx(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN), 0, 0, 0, 0, 0);
    add_row(vtx(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MIN), 0, 0, 0, 0, 0);
    add_row(vtx(FX_MIN, FX_MAX, 0, FX_MIN, FX_MAX), 0, 0, 0, 0, 0);
    add_row(vtx(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX), 0, 0, 0, 0, 0);
    add_row(vtx(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MAX), 0, 0, 0, 0, 0);
    add_row(vtx(0, FX_MIN, FX_MAX, FX_MAX, FX_MIN), 0, 0, 0, 0, 0);
    // equal components
    add_row(vtx(0, 0, 0, 0, 0), 0, 0, 0, 0, 0);
    add_row(vtx(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 0), 0, 0, 0, 0, 0);
    add_row(vtx(0, FX_ONE, 0, 0, FX_ONE), 0, 0, 0, 0, 0);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      row_known   = directed[i].known;
      row_tangent = directed[i].tangent;
      send_vertex(directed[i].vert, $urandom_range(0, 5), 1'b0);
    end
    row_known = 1'b0;

    for (int tri_idx = 0; tri_idx < RANDOM_TRIS; tri_idx++) begin
      no_idle = ((tri_idx / 12) % 3 == 1);
      kind = $urandom_range(0, 99);
      for (int k = 0; k < 3; k++) begin
        if (kind < 15)
          tri_v[k] = vtx($urandom, $urandom, $urandom, $urandom, $urandom);
        else if (kind >= 88)
          tri_v[k] = vtx($urandom, $urandom, $urandom, small_fx(), small_fx());
        else
          tri_v[k] = vtx(small_fx(), small_fx(), small_fx(), small_fx(), small_fx());
      end
      if (kind >= 15 && kind < 23) begin
        tri_v[1].tex_u = tri_v[0].tex_u;
        tri_v[1].tex_v = tri_v[0].tex_v;
        tri_v[2].tex_u = tri_v[0].tex_u;
        tri_v[2].tex_v = tri_v[0].tex_v;
      end else if (kind >= 23 && kind < 29) begin
        for (int k = 1; k < 3; k++) begin
          tri_v[k].pos_x = tri_v[0].pos_x;
          tri_v[k].pos_y = tri_v[0].pos_y;
          tri_v[k].pos_z = tri_v[0].pos_z;
        end
      end
      for (int k = 0; k < 3; k++)
        send_vertex(tri_v[k], no_idle ? 0 : $urandom_range(0, 5),
                    tri_idx == PAUSE_TRI && k == 0);
    end
    in_valid <= 1'b0;

    while (tangent_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d vertices in (directed extremes, degenerate and random triangles)",
             vertices_sent);
    $display("%0d tangent results checked, %0d flagged degenerate, %0d mismatches",
             results_checked, degenerate_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
